### rtl/core/spmf_pkg.sv
`timescale 1ns / 1ps

package spmf_pkg;

  localparam int LEVELS_DEF      = 8;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  // level index field in the command, wide enough for the largest LEVELS
  localparam int LV_IDX_W = 6;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PRIO = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    LV_NOP,
    LV_PUSH,
    LV_POP,
    LV_CLEAR
  } lv_op_t;

  typedef struct packed {
    lv_op_t              op;
    logic [LV_IDX_W-1:0] lv;
  } lv_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_BACK,
    S_DONE,
    S_CLR
  } state_t;

endpackage

### rtl/core/spmf_store.sv
`timescale 1ns / 1ps

module spmf_store #(
  parameter int DEPTH      = 128,
  parameter int ADDR_W     = 7,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/spmf_levels.sv
`timescale 1ns / 1ps

module spmf_levels import spmf_pkg::*; #(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int LV_W        = $clog2(LEVELS),
  parameter int PTR_W       = $clog2(LEVEL_DEPTH),
  parameter int CNT_W       = $clog2(LEVEL_DEPTH + 1),
  parameter int ADDR_W      = $clog2(LEVELS * LEVEL_DEPTH),
  parameter int TOT_W       = $clog2(LEVELS * LEVEL_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lv_cmd_t           cmd,
  output logic              sel_full,
  output logic              nonempty,
  output logic [ADDR_W-1:0] push_addr,
  output logic [ADDR_W-1:0] head_addr,
  output logic [ADDR_W-1:0] back_addr,
  output logic [TOT_W-1:0]  total
);

  logic [PTR_W-1:0] head_r [LEVELS];
  logic [PTR_W-1:0] tail_r [LEVELS];
  logic [CNT_W-1:0] cnt_r  [LEVELS];
  logic [TOT_W-1:0] total_r;

  logic [LV_W-1:0]  sel_lv;
  logic [LV_W-1:0]  hi_lv;
  logic [LV_W-1:0]  lo_lv;
  logic [PTR_W-1:0] last_ptr;

  assign sel_lv = cmd.lv[LV_W-1:0];

  always_comb begin
    nonempty = 1'b0;
    hi_lv    = '0;
    lo_lv    = '0;
    // ascending scan: last hit is the highest non-empty level
    for (int i = 0; i < LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        nonempty = 1'b1;
        hi_lv    = LV_W'(i);
      end
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        lo_lv = LV_W'(i);
      end
    end
    last_ptr  = (tail_r[lo_lv] == '0) ? PTR_W'(LEVEL_DEPTH - 1) : tail_r[lo_lv] - 1'b1;
    sel_full  = (cnt_r[sel_lv] == CNT_W'(LEVEL_DEPTH));
    push_addr = ADDR_W'(ADDR_W'(sel_lv) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(tail_r[sel_lv]);
    head_addr = ADDR_W'(ADDR_W'(hi_lv) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(head_r[hi_lv]);
    back_addr = ADDR_W'(ADDR_W'(lo_lv) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(last_ptr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      total_r <= '0;
    end else begin
      case (cmd.op)
        LV_PUSH: begin
          tail_r[sel_lv] <= (tail_r[sel_lv] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                            : tail_r[sel_lv] + 1'b1;
          cnt_r[sel_lv]  <= cnt_r[sel_lv] + 1'b1;
          total_r        <= total_r + 1'b1;
        end
        LV_POP: begin
          head_r[hi_lv] <= (head_r[hi_lv] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                           : head_r[hi_lv] + 1'b1;
          cnt_r[hi_lv]  <= cnt_r[hi_lv] - 1'b1;
          total_r       <= total_r - 1'b1;
        end
        LV_CLEAR: begin
          head_r[sel_lv] <= '0;
          tail_r[sel_lv] <= '0;
          cnt_r[sel_lv]  <= '0;
          total_r        <= total_r - TOT_W'(cnt_r[sel_lv]);
        end
        default: begin
        end
      endcase
    end
  end

  assign total = total_r;

endmodule

### rtl/core/strict_priority_multi_fifo_unit.sv
`timescale 1ns / 1ps

// Strict priority queue: one FIFO of LEVEL_DEPTH words per priority level.
// Input: pulse start with in_action/in_value/in_priority_req while busy is low.
//   Push (action 0) appends in_value to its level; pop (action 1) removes the
//   front of the highest non-empty level. Bad requests change nothing and
//   report a status.
// Output: out_valid strobes for one cycle in S_DONE, after S_TOP and S_BACK,
//   with status, popped word, top (front of highest non-empty level), back
//   (newest entry of lowest non-empty level), total count and empty flag.
//   The receiver cannot stall; each result is shown once.
// One item at a time (busy until shown): the entry memory has a single read
//   port and each item reads it up to three times in turn (pop, top, back).
// Config: cfg_levels_in_use is taken when cfg_valid and cfg_ready are high;
//   cfg_ready is low while busy or while start is high (an item goes first).
//   A write starts an S_CLR sweep from level LEVELS-1 down to 0 that empties
//   the levels at or above the new count; busy stays high meanwhile.
// Reset (rst_n low, synchronous): all levels empty, levels_in_use = LEVELS.
//   Entry memory is not cleared; only occupied entries reach the outputs, else 0.
module strict_priority_multi_fifo_unit import spmf_pkg::*; #(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_value,
  input  logic [2:0]  in_priority_req,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_levels_in_use,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_pop_valid,
  output logic [31:0] out_pop_value,
  output logic [31:0] out_top_value,
  output logic [31:0] out_back_value,
  output logic [7:0]  out_total_count,
  output logic        out_is_empty
);

  localparam int LV_W   = $clog2(LEVELS);
  localparam int LVC_W  = $clog2(LEVELS + 1);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int DEPTH  = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TOT_W  = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [LVC_W-1:0]  lvl_use_r;
  logic [LV_W-1:0]   clr_r;
  status_t           status_r, status_nxt;
  logic              pop_valid_r, pop_hit;
  logic [31:0]       pop_value_r;
  logic [31:0]       top_r;

  lv_cmd_t           cmd;
  logic              sel_full;
  logic              nonempty;
  logic [ADDR_W-1:0] push_addr, head_addr, back_addr, raddr;
  logic [TOT_W-1:0]  total;
  logic              we;
  logic [DATA_WIDTH-1:0] rdata;

  logic accept, cfg_wr, prio_bad;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign prio_bad  = (int'(in_priority_req) >= int'(lvl_use_r)) ||
                     (int'(in_priority_req) >= LEVELS);

  spmf_levels #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .LV_W        (LV_W),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W),
    .TOT_W       (TOT_W)
  ) u_levels (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sel_full  (sel_full),
    .nonempty  (nonempty),
    .push_addr (push_addr),
    .head_addr (head_addr),
    .back_addr (back_addr),
    .total     (total)
  );

  spmf_store #(
    .DEPTH      (DEPTH),
    .ADDR_W     (ADDR_W),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (push_addr),
    .wdata (DATA_WIDTH'(in_value)),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    pop_hit    = 1'b0;
    cmd.op     = LV_NOP;
    cmd.lv     = LV_IDX_W'(in_priority_req);
    we         = 1'b0;
    raddr      = head_addr;
    case (state_r)
      S_IDLE: begin
        if (cfg_wr) begin
          state_nxt = S_CLR;
        end else if (accept) begin
          state_nxt = S_TOP;
          if (in_action == ACT_PUSH) begin
            if (prio_bad) begin
              status_nxt = ST_BAD_PRIO;
            end else if (sel_full) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_OK;
              cmd.op     = LV_PUSH;
              we         = 1'b1;
            end
          end else if (nonempty) begin
            // read of the popped word goes out with the pointer update
            status_nxt = ST_OK;
            cmd.op     = LV_POP;
            pop_hit    = 1'b1;
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
      end
      S_TOP: begin
        raddr     = head_addr;
        state_nxt = S_BACK;
      end
      S_BACK: begin
        raddr     = back_addr;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        cmd.lv = LV_IDX_W'(clr_r);
        if (int'(clr_r) >= int'(lvl_use_r)) begin
          cmd.op = LV_CLEAR;
        end
        if (clr_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_use_r   <= LVC_W'(LEVELS);
      clr_r       <= '0;
      status_r    <= ST_OK;
      pop_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (int'(cfg_levels_in_use) > LEVELS) begin
          lvl_use_r <= LVC_W'(LEVELS);
        end else begin
          lvl_use_r <= LVC_W'(cfg_levels_in_use);
        end
        clr_r <= LV_W'(LEVELS - 1);
      end else if (state_r == S_CLR) begin
        clr_r <= clr_r - 1'b1;
      end
      if (state_r == S_IDLE && accept && !cfg_wr) begin
        status_r    <= status_nxt;
        pop_valid_r <= pop_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_TOP) begin
      pop_value_r <= pop_valid_r ? 32'(rdata) : 32'd0;
    end
    if (state_r == S_BACK) begin
      top_r <= nonempty ? 32'(rdata) : 32'd0;
    end
  end

  assign out_valid       = (state_r == S_DONE);
  assign out_status      = status_r;
  assign out_pop_valid   = pop_valid_r;
  assign out_pop_value   = pop_value_r;
  assign out_top_value   = top_r;
  assign out_back_value  = nonempty ? 32'(rdata) : 32'd0;
  assign out_total_count = 8'(total);
  assign out_is_empty    = !nonempty;

endmodule
